/* rtl/sha384s_pkg.sv */
// SHA-384 stream hasher package: shared types, round constants and initial hash values.
// No dependencies; used by every module of the hasher.
`default_nettype none
package sha384s_pkg;

    typedef logic [63:0] word_t;

    typedef struct packed {
        logic start;
        logic init;
    } core_ctrl_t;

    function automatic word_t round_k(input logic [6:0] r);
        word_t k;
        case (r)
            7'd0: k = 64'h428a2f98d728ae22;   7'd1: k = 64'h7137449123ef65cd;
            7'd2: k = 64'hb5c0fbcfec4d3b2f;   7'd3: k = 64'he9b5dba58189dbbc;
            7'd4: k = 64'h3956c25bf348b538;   7'd5: k = 64'h59f111f1b605d019;
            7'd6: k = 64'h923f82a4af194f9b;   7'd7: k = 64'hab1c5ed5da6d8118;
            7'd8: k = 64'hd807aa98a3030242;   7'd9: k = 64'h12835b0145706fbe;
            7'd10: k = 64'h243185be4ee4b28c;  7'd11: k = 64'h550c7dc3d5ffb4e2;
            7'd12: k = 64'h72be5d74f27b896f;  7'd13: k = 64'h80deb1fe3b1696b1;
            7'd14: k = 64'h9bdc06a725c71235;  7'd15: k = 64'hc19bf174cf692694;
            7'd16: k = 64'he49b69c19ef14ad2;  7'd17: k = 64'hefbe4786384f25e3;
            7'd18: k = 64'h0fc19dc68b8cd5b5;  7'd19: k = 64'h240ca1cc77ac9c65;
            7'd20: k = 64'h2de92c6f592b0275;  7'd21: k = 64'h4a7484aa6ea6e483;
            7'd22: k = 64'h5cb0a9dcbd41fbd4;  7'd23: k = 64'h76f988da831153b5;
            7'd24: k = 64'h983e5152ee66dfab;  7'd25: k = 64'ha831c66d2db43210;
            7'd26: k = 64'hb00327c898fb213f;  7'd27: k = 64'hbf597fc7beef0ee4;
            7'd28: k = 64'hc6e00bf33da88fc2;  7'd29: k = 64'hd5a79147930aa725;
            7'd30: k = 64'h06ca6351e003826f;  7'd31: k = 64'h142929670a0e6e70;
            7'd32: k = 64'h27b70a8546d22ffc;  7'd33: k = 64'h2e1b21385c26c926;
            7'd34: k = 64'h4d2c6dfc5ac42aed;  7'd35: k = 64'h53380d139d95b3df;
            7'd36: k = 64'h650a73548baf63de;  7'd37: k = 64'h766a0abb3c77b2a8;
            7'd38: k = 64'h81c2c92e47edaee6;  7'd39: k = 64'h92722c851482353b;
            7'd40: k = 64'ha2bfe8a14cf10364;  7'd41: k = 64'ha81a664bbc423001;
            7'd42: k = 64'hc24b8b70d0f89791;  7'd43: k = 64'hc76c51a30654be30;
            7'd44: k = 64'hd192e819d6ef5218;  7'd45: k = 64'hd69906245565a910;
            7'd46: k = 64'hf40e35855771202a;  7'd47: k = 64'h106aa07032bbd1b8;
            7'd48: k = 64'h19a4c116b8d2d0c8;  7'd49: k = 64'h1e376c085141ab53;
            7'd50: k = 64'h2748774cdf8eeb99;  7'd51: k = 64'h34b0bcb5e19b48a8;
            7'd52: k = 64'h391c0cb3c5c95a63;  7'd53: k = 64'h4ed8aa4ae3418acb;
            7'd54: k = 64'h5b9cca4f7763e373;  7'd55: k = 64'h682e6ff3d6b2b8a3;
            7'd56: k = 64'h748f82ee5defb2fc;  7'd57: k = 64'h78a5636f43172f60;
            7'd58: k = 64'h84c87814a1f0ab72;  7'd59: k = 64'h8cc702081a6439ec;
            7'd60: k = 64'h90befffa23631e28;  7'd61: k = 64'ha4506cebde82bde9;
            7'd62: k = 64'hbef9a3f7b2c67915;  7'd63: k = 64'hc67178f2e372532b;
            7'd64: k = 64'hca273eceea26619c;  7'd65: k = 64'hd186b8c721c0c207;
            7'd66: k = 64'heada7dd6cde0eb1e;  7'd67: k = 64'hf57d4f7fee6ed178;
            7'd68: k = 64'h06f067aa72176fba;  7'd69: k = 64'h0a637dc5a2c898a6;
            7'd70: k = 64'h113f9804bef90dae;  7'd71: k = 64'h1b710b35131c471b;
            7'd72: k = 64'h28db77f523047d84;  7'd73: k = 64'h32caab7b40c72493;
            7'd74: k = 64'h3c9ebe0a15c9bebc;  7'd75: k = 64'h431d67c49c100d4c;
            7'd76: k = 64'h4cc5d4becb3e42b6;  7'd77: k = 64'h597f299cfc657e2a;
            7'd78: k = 64'h5fcb6fab3ad6faec;  7'd79: k = 64'h6c44198c4a475817;
            default: k = '0;
        endcase
        return k;
    endfunction

    function automatic word_t init_hash(input logic [2:0] i);
        word_t h;
        case (i)
            3'd0: h = 64'hcbbb9d5dc1059ed8;
            3'd1: h = 64'h629a292a367cd507;
            3'd2: h = 64'h9159015a3070dd17;
            3'd3: h = 64'h152fecd8f70e5939;
            3'd4: h = 64'h67332667ffc00b31;
            3'd5: h = 64'h8eb44a8768581511;
            3'd6: h = 64'hdb0c2e0d64f98fa7;
            3'd7: h = 64'h47b5481dbefa4fa4;
            default: h = '0;
        endcase
        return h;
    endfunction

    localparam logic [6:0] LAST_ROUND = 7'd79;
    localparam logic [3:0] LEN_SLOT = 4'd14;
    localparam logic [2:0] LAST_DIGEST_WORD = 3'd5;

endpackage
`default_nettype wire

/* rtl/sha384s_buf.sv */
// Sixteen-word block buffer: one write port, one read port with registered read data.
// Uses sha384s_pkg for the word type.
`default_nettype none
module sha384s_buf (
    input  wire logic               aclk,
    input  wire logic               wr_en,
    input  wire logic [3:0]         wr_addr,
    input  wire sha384s_pkg::word_t wr_data,
    input  wire logic [3:0]         rd_addr,
    output sha384s_pkg::word_t      rd_data
);
    import sha384s_pkg::*;

    word_t mem [16];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

/* rtl/sha384s_core.sv */
// SHA-384 compression: loads the block buffer into a schedule window, runs one round
// per cycle and folds the result into the chaining value. Uses sha384s_pkg.
`default_nettype none
module sha384s_core (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire sha384s_pkg::core_ctrl_t  ctrl,
    output logic [3:0]                    rd_addr,
    input  wire sha384s_pkg::word_t       rd_data,
    input  wire logic [2:0]               digest_sel,
    output sha384s_pkg::word_t            digest_word,
    output logic                          done
);
    import sha384s_pkg::*;

    typedef enum logic [3:0] {
        C_IDLE  = 4'b0001,
        C_LOAD  = 4'b0010,
        C_ROUND = 4'b0100,
        C_ADD   = 4'b1000
    } cstate_t;

    cstate_t state_reg, state_next;
    logic [6:0] cnt_reg, cnt_next;
    word_t chain_reg [8];
    word_t var_reg [8];
    word_t win_reg [16];

    function automatic word_t rotr(input word_t x, input int n);
        return (x >> n) | (x << (64 - n));
    endfunction

    word_t t1, t2, wnew, e, a;

    assign rd_addr = cnt_reg[3:0];
    assign digest_word = chain_reg[digest_sel];
    assign done = (state_reg == C_ADD);

    always_comb begin
        e = var_reg[4];
        a = var_reg[0];
        t1 = var_reg[7] + (rotr(e, 14) ^ rotr(e, 18) ^ rotr(e, 41))
           + ((e & var_reg[5]) ^ (~e & var_reg[6])) + round_k(cnt_reg) + win_reg[0];
        t2 = (rotr(a, 28) ^ rotr(a, 34) ^ rotr(a, 39))
           + ((a & var_reg[1]) ^ (a & var_reg[2]) ^ (var_reg[1] & var_reg[2]));
        wnew = (rotr(win_reg[14], 19) ^ rotr(win_reg[14], 61) ^ (win_reg[14] >> 6))
             + win_reg[9]
             + (rotr(win_reg[1], 1) ^ rotr(win_reg[1], 8) ^ (win_reg[1] >> 7))
             + win_reg[0];
    end

    always_comb begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        case (state_reg)
            C_IDLE: begin
                if (ctrl.start) begin
                    state_next = C_LOAD;
                    cnt_next = '0;
                end
            end
            C_LOAD: begin
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'd16) begin
                    state_next = C_ROUND;
                    cnt_next = '0;
                end
            end
            C_ROUND: begin
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == LAST_ROUND) begin
                    state_next = C_ADD;
                end
            end
            C_ADD: begin
                state_next = C_IDLE;
            end
            default: begin
                state_next = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= C_IDLE;
            cnt_reg <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || ctrl.init) begin
            for (int i = 0; i < 8; i++) begin
                chain_reg[i] <= init_hash(3'(i));
            end
        end else if (state_reg == C_ADD) begin
            for (int i = 0; i < 8; i++) begin
                chain_reg[i] <= chain_reg[i] + var_reg[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == C_LOAD && cnt_reg != 7'd0) begin
            for (int i = 0; i < 15; i++) begin
                win_reg[i] <= win_reg[i + 1];
            end
            win_reg[15] <= rd_data;
        end else if (state_reg == C_ROUND) begin
            for (int i = 0; i < 15; i++) begin
                win_reg[i] <= win_reg[i + 1];
            end
            win_reg[15] <= wnew;
        end
        if (state_reg == C_LOAD) begin
            for (int i = 0; i < 8; i++) begin
                var_reg[i] <= chain_reg[i];
            end
        end else if (state_reg == C_ROUND) begin
            var_reg[7] <= var_reg[6];
            var_reg[6] <= var_reg[5];
            var_reg[5] <= var_reg[4];
            var_reg[4] <= var_reg[3] + t1;
            var_reg[3] <= var_reg[2];
            var_reg[2] <= var_reg[1];
            var_reg[1] <= var_reg[0];
            var_reg[0] <= t1 + t2;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == C_ROUND) |-> (cnt_reg <= LAST_ROUND))
        else $error("round counter beyond last round");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == C_ADD) |-> $past(state_reg == C_ROUND && cnt_reg == LAST_ROUND))
        else $error("chain update without full round pass");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.start && state_reg == C_IDLE) |=> (state_reg == C_LOAD))
        else $error("start not taken");

endmodule
`default_nettype wire

/* rtl/sha384_stream_hasher.sv */
// SHA-384 stream hasher top level: input sequencer, padding, length count and digest output.
// Instantiates sha384s_buf and sha384s_core; uses sha384s_pkg.
//
// Usage: the message enters on the s_ channel as big-endian 64-bit items, first byte in
// bits 63:56. s_tuser carries the count of valid bytes, which matters only on the item
// with s_tlast high; all earlier items are full. After the last item the block pads the
// message, appends the 128-bit bit count and sends the 384-bit digest on the m_ channel
// as six items, most significant word first, m_tuser giving the word position and m_tlast
// marking the sixth word.
// Flow: items that do not complete a block are accepted back to back. The sixteenth item
// of a block starts a compression (the 16 buffer words streamed through the registered
// read, 80 rounds on the single round unit, one chain update), during which no input is
// taken. After a last item the block writes the padding words and runs one or two
// compressions before the first digest word appears. No input is taken until the sixth
// digest word leaves.
// Reset restores the initial hash value and clears the bit count and buffer fill. A stall
// on m_tready holds the current digest word; nothing is lost.
`default_nettype none
module sha384_stream_hasher (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // message_word
    input  wire logic [3:0]  s_tuser,   // valid_bytes
    input  wire logic        s_tlast,   // last_word
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,   // digest_word
    output logic [2:0]       m_tuser,   // word_index
    output logic             m_tlast    // digest_done
);
    import sha384s_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_PAD  = 4'b0010,
        ST_HASH = 4'b0100,
        ST_OUT  = 4'b1000
    } state_t;

    typedef enum logic [2:0] {
        PAD_EXTRA = 3'b001,
        PAD_ZERO  = 3'b010,
        PAD_LENLO = 3'b100
    } pad_t;

    state_t state_reg, state_next, after_reg, after_next;
    pad_t pad_reg, pad_next;
    logic [3:0] fill_reg, fill_next;
    logic [2:0] idx_reg, idx_next;
    logic [127:0] len_reg, len_next;

    logic push;
    word_t push_data;
    core_ctrl_t ctrl;
    logic core_done;
    logic [3:0] rd_addr;
    word_t rd_data;
    logic [3:0] nbytes;
    word_t keep_mask, pad_byte;
    logic s_acc, m_acc;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tuser = idx_reg;
    assign m_tlast = (idx_reg == LAST_DIGEST_WORD);
    assign s_acc = s_tvalid && s_tready;
    assign m_acc = m_tvalid && m_tready;

    assign nbytes = (s_tuser > 4'd8) ? 4'd8 : s_tuser;
    assign keep_mask = ~({64{1'b1}} >> {nbytes, 3'b000});
    assign pad_byte = 64'h8000_0000_0000_0000 >> {nbytes, 3'b000};

    always_comb begin
        state_next = state_reg;
        after_next = after_reg;
        pad_next = pad_reg;
        fill_next = fill_reg;
        idx_next = idx_reg;
        len_next = len_reg;
        push = 1'b0;
        push_data = '0;
        ctrl = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    push = 1'b1;
                    if (!s_tlast) begin
                        len_next = len_reg + 128'd64;
                        push_data = s_tdata;
                        after_next = ST_IDLE;
                        state_next = ST_IDLE;
                    end else begin
                        len_next = len_reg + {121'd0, nbytes, 3'b000};
                        if (nbytes == 4'd8) begin
                            push_data = s_tdata;
                            pad_next = PAD_EXTRA;
                        end else begin
                            push_data = (s_tdata & keep_mask) | pad_byte;
                            pad_next = PAD_ZERO;
                        end
                        after_next = ST_PAD;
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                push = 1'b1;
                case (pad_reg)
                    PAD_EXTRA: begin
                        push_data = 64'h8000_0000_0000_0000;
                        pad_next = PAD_ZERO;
                    end
                    PAD_ZERO: begin
                        if (fill_reg == LEN_SLOT) begin
                            push_data = len_reg[127:64];
                            pad_next = PAD_LENLO;
                        end else begin
                            push_data = '0;
                        end
                    end
                    PAD_LENLO: begin
                        push_data = len_reg[63:0];
                        after_next = ST_OUT;
                    end
                    default: begin
                        push_data = '0;
                    end
                endcase
            end
            ST_HASH: begin
                if (core_done) begin
                    state_next = after_reg;
                    idx_next = '0;
                end
            end
            ST_OUT: begin
                if (m_acc) begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == LAST_DIGEST_WORD) begin
                        ctrl.init = 1'b1;
                        len_next = '0;
                        fill_next = '0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        if (push) begin
            fill_next = fill_reg + 4'd1;
            if (fill_reg == 4'd15) begin
                ctrl.start = 1'b1;
                state_next = ST_HASH;
            end else if (state_reg == ST_PAD) begin
                state_next = ST_PAD;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            after_reg <= ST_IDLE;
            pad_reg <= PAD_ZERO;
            fill_reg <= '0;
            idx_reg <= '0;
            len_reg <= '0;
        end else begin
            state_reg <= state_next;
            after_reg <= after_next;
            pad_reg <= pad_next;
            fill_reg <= fill_next;
            idx_reg <= idx_next;
            len_reg <= len_next;
        end
    end

    sha384s_buf u_buf (
        .aclk    (aclk),
        .wr_en   (push),
        .wr_addr (fill_reg),
        .wr_data (push_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    sha384s_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctrl        (ctrl),
        .rd_addr     (rd_addr),
        .rd_data     (rd_data),
        .digest_sel  (idx_reg),
        .digest_word (m_tdata),
        .done        (core_done)
    );

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT) |-> (fill_reg == 4'd0))
        else $error("digest sent with partial block in buffer");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_HASH) |-> !push)
        else $error("buffer written during compression");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_acc && m_tlast) |=> (fill_reg == 4'd0 && len_reg == 128'd0))
        else $error("state not restarted after digest");
    assert property (@(posedge aclk) disable iff (!aresetn)
        core_done |-> (state_reg == ST_HASH))
        else $error("compression finished outside hash phase");

endmodule
`default_nettype wire

/* tb/sv/tb_top.sv */
// Self-checking testbench for sha384_stream_hasher: messages enter as 64-bit items and each
// digest word is compared with a SHA-384 predictor kept in the testbench. Uses sha384s_pkg.
`timescale 1ns / 1ps
module tb_top;
    import sha384s_pkg::*;

    typedef struct packed {
        logic [63:0] word;
        logic [2:0]  index;
        logic        done;
    } digest_item_t;

    localparam int SEND_GAP_PCT_A = 32;
    localparam int RECV_GAP_PCT_A = 84;
    localparam int CYCLE_LIMIT    = 2000000;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic [3:0]  s_tuser;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    sha384_stream_hasher dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

    // Predictor state.
    logic [63:0] hash_state [8];
    logic [63:0] msg_block [16];
    logic [127:0] msg_bits;
    int unsigned words_held;

    digest_item_t digest_queue[$];
    int error_count;
    int send_gap_pct;
    int recv_gap_pct;
    int hold_cycles;
    longint cycle_count;

    localparam logic [63:0] ROUND_CONST [80] = '{
        64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
        64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
        64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
        64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
        64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
        64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
        64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
        64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
        64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
        64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
        64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
        64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
        64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
        64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
        64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
        64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
        64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
        64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
        64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
        64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
    };

    localparam logic [63:0] START_HASH [8] = '{
        64'hcbbb9d5dc1059ed8, 64'h629a292a367cd507, 64'h9159015a3070dd17, 64'h152fecd8f70e5939,
        64'h67332667ffc00b31, 64'h8eb44a8768581511, 64'hdb0c2e0d64f98fa7, 64'h47b5481dbefa4fa4
    };

    function automatic logic [63:0] ror64(logic [63:0] x, int n);
        return (x >> n) | (x << (64 - n));
    endfunction

    task automatic compress_block();
        logic [63:0] w [80];
        logic [63:0] v [8];
        logic [63:0] t1, t2, s0, s1;
        for (int r = 0; r < 16; r++) w[r] = msg_block[r];
        for (int r = 16; r < 80; r++) begin
            s0 = ror64(w[r-15], 1) ^ ror64(w[r-15], 8) ^ (w[r-15] >> 7);
            s1 = ror64(w[r-2], 19) ^ ror64(w[r-2], 61) ^ (w[r-2] >> 6);
            w[r] = s1 + w[r-7] + s0 + w[r-16];
        end
        for (int k = 0; k < 8; k++) v[k] = hash_state[k];
        for (int r = 0; r < 80; r++) begin
            t1 = v[7] + (ror64(v[4], 14) ^ ror64(v[4], 18) ^ ror64(v[4], 41))
                + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_CONST[r] + w[r];
            t2 = (ror64(v[0], 28) ^ ror64(v[0], 34) ^ ror64(v[0], 39))
                + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int k = 0; k < 8; k++) hash_state[k] += v[k];
    endtask

    task automatic append_word(logic [63:0] w);
        msg_block[words_held] = w;
        words_held++;
        if (words_held == 16) begin
            compress_block();
            words_held = 0;
        end
    endtask

    task automatic restart_message();
        for (int k = 0; k < 8; k++) hash_state[k] = START_HASH[k];
        msg_bits = '0;
        words_held = 0;
    endtask

    task automatic predict_item(logic [63:0] data, logic [3:0] nbytes, logic last);
        int unsigned n;
        logic [63:0] mask;
        digest_item_t d;
        if (!last) begin
            msg_bits += 128'd64;
            append_word(data);
            return;
        end
        n = (nbytes > 8) ? 8 : nbytes;
        msg_bits += 128'(n * 8);
        if (n == 8) begin
            append_word(data);
            append_word(64'h8000000000000000);
        end else begin
            mask = (n == 0) ? 64'd0 : ~64'd0 << (64 - 8 * n);
            append_word((data & mask) | (64'h80 << (56 - 8 * n)));
        end
        if (words_held > LEN_SLOT) begin
            while (words_held != 0) append_word(64'd0);
        end
        while (words_held < LEN_SLOT) append_word(64'd0);
        append_word(msg_bits[127:64]);
        append_word(msg_bits[63:0]);
        for (int k = 0; k < 6; k++) begin
            d.word = hash_state[k];
            d.index = 3'(k);
            d.done = (k == LAST_DIGEST_WORD);
            digest_queue.push_back(d);
        end
        restart_message();
    endtask

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Receiver: random stalls plus an optional long hold-off.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_gap_pct);
        end
    end

    always @(posedge aclk) begin
        digest_item_t exp_item;
        if (aresetn && m_tvalid && m_tready) begin
            if (digest_queue.size() == 0) begin
                $error("digest word with no expectation: %h", m_tdata);
                error_count++;
            end else begin
                exp_item = digest_queue.pop_front();
                if (m_tdata !== exp_item.word) begin
                    $error("digest_word expected %h actual %h", exp_item.word, m_tdata);
                    error_count++;
                end
                if (m_tuser !== exp_item.index) begin
                    $error("word_index expected %0d actual %0d", exp_item.index, m_tuser);
                    error_count++;
                end
                if (m_tlast !== exp_item.done) begin
                    $error("digest_done expected %0b actual %0b", exp_item.done, m_tlast);
                    error_count++;
                end
            end
        end
    end

    // The valid flag stays high after an item until the next item or an idle cycle.
    task automatic send_item(logic [63:0] data, logic [3:0] nbytes, logic last);
        while ($urandom_range(99) < send_gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= nbytes;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_item(data, nbytes, last);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (digest_queue.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic send_message(int unsigned nwords, logic [3:0] last_bytes);
        for (int i = 0; i + 1 < nwords; i++)
            send_item({$urandom, $urandom}, 4'($urandom_range(15)), 1'b0);
        send_item({$urandom, $urandom}, last_bytes, 1'b1);
    endtask

    task automatic test_directed();
        send_item(64'd0, 4'd0, 1'b1);
        send_item(64'h6162638000000000, 4'd3, 1'b1);
        send_item(~64'd0, 4'd8, 1'b1);
        send_item(~64'd0, 4'd15, 1'b1);
        send_item(64'hffffffffffffffff, 4'd7, 1'b1);
        for (int i = 0; i < 14; i++) send_item(~64'd0, 4'd2, 1'b0);
        send_item(64'h0123456789abcdef, 4'd6, 1'b1);
        send_item(64'haaaaaaaaaaaaaaaa, 4'd1, 1'b0);
        send_item(64'h5555555555555555, 4'd0, 1'b1);
        wait_drained();
    endtask

    task automatic test_random(int unsigned nitems);
        int unsigned sent;
        int unsigned len;
        sent = 0;
        while (sent < nitems) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(17, 34) : $urandom_range(1, 17);
            send_message(len, 4'($urandom_range(15)));
            sent += len;
        end
        wait_drained();
    endtask

    task automatic test_backpressure();
        hold_cycles = 600;
        send_message(40, 4'd8);
        send_message(3, 4'd5);
        wait_drained();
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        s_tlast = 1'b0;
        error_count = 0;
        cycle_count = 0;
        hold_cycles = 0;
        send_gap_pct = SEND_GAP_PCT_A;
        recv_gap_pct = RECV_GAP_PCT_A;
        restart_message();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random(90);
        send_gap_pct = RECV_GAP_PCT_A;
        recv_gap_pct = SEND_GAP_PCT_A;
        test_random(90);
        send_gap_pct = 0;
        recv_gap_pct = 0;
        test_random(90);
        test_backpressure();
        repeat (50) @(posedge aclk);
        if (error_count == 0 && digest_queue.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
